>>> src/teq_pkg.sv
// shared constants, codes and control types for the timed event queue
package teq_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TIME_W = 48;
    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] FIRST_ID = 32'd100;
    localparam logic [WORD_W-1:0] MAX_BLOCK_RESET = 32'd4096;

    localparam logic [2:0] FUNC_ADD_RUN  = 3'd0;
    localparam logic [2:0] FUNC_ADD_ONLY = 3'd1;
    localparam logic [2:0] FUNC_ADD_HEAD = 3'd2;
    localparam logic [2:0] FUNC_DELETE   = 3'd3;
    localparam logic [2:0] FUNC_SERVICE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_DUE   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load_req;
        logic find;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage

>>> src/teq_ctrl.sv
// controller state machine: request load, search pass, execute
module teq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  teq_pkg::stat_t  stat,
    output teq_pkg::cmd_t   cmd
);

    teq_pkg::state_t state_reg;
    teq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= teq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            teq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = teq_pkg::S_FIND;
                end
            end
            teq_pkg::S_FIND:
            begin
                state_next = teq_pkg::S_EXEC;
            end
            teq_pkg::S_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    state_next = teq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = teq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            teq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_req = in_valid;
            end
            teq_pkg::S_FIND:
            begin
                cmd.find = 1'b1;
            end
            teq_pkg::S_EXEC:
            begin
                cmd.exec = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/teq_datapath.sv
// event table, search logic, result register and configuration register
module teq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  teq_pkg::cmd_t                 cmd,
    output teq_pkg::stat_t                stat,
    input  logic                          cfg_valid,
    input  logic [teq_pkg::WORD_W-1:0]    cfg_data,
    input  logic [2:0]                    func,
    input  logic [teq_pkg::TIME_W-1:0]    timecode,
    input  logic [teq_pkg::WORD_W-1:0]    event_key,
    input  logic [teq_pkg::WORD_W-1:0]    event_tag,
    input  logic [teq_pkg::WORD_W-1:0]    target_id,
    input  logic [teq_pkg::TIME_W-1:0]    now_time,
    input  logic [teq_pkg::WORD_W-1:0]    cycle_budget,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [teq_pkg::WORD_W-1:0]    assigned_id,
    output logic                          fired,
    output logic [teq_pkg::WORD_W-1:0]    fired_key,
    output logic [teq_pkg::WORD_W-1:0]    fired_tag,
    output logic                          tag_hit,
    output logic [teq_pkg::WORD_W-1:0]    jitter,
    output logic [teq_pkg::WORD_W-1:0]    cycles_to_run
);

    localparam int D = teq_pkg::DEPTH;
    localparam int CW = teq_pkg::CNT_W;
    localparam int TW = teq_pkg::TIME_W;
    localparam int WW = teq_pkg::WORD_W;

    // table storage
    logic [TW-1:0] slot_time_reg [D];
    logic [WW-1:0] slot_key_reg  [D];
    logic [WW-1:0] slot_id_reg   [D];
    logic [WW-1:0] slot_tag_reg  [D];

    logic [CW-1:0] count_reg, count_next;
    logic [WW-1:0] next_id_reg, next_id_next;
    logic [WW-1:0] max_block_reg;

    // latched request
    logic [2:0]    rq_func_reg;
    logic [TW-1:0] rq_time_reg;
    logic [WW-1:0] rq_key_reg, rq_tag_reg, rq_target_reg, rq_budget_reg;
    logic [TW-1:0] rq_now_reg;

    // search results
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] mpos_reg, mpos_next;
    logic          found_reg, found_next;
    logic          due_reg, head_ready_reg;
    logic [TW-1:0] late_reg, early_reg;

    // result register
    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [WW-1:0] assigned_id_reg, fired_key_reg, fired_tag_reg;
    logic [WW-1:0] jitter_reg, cycles_reg;
    logic          fired_reg, tag_hit_reg;

    logic [2:0]    r_status;
    logic [WW-1:0] r_assigned, r_key, r_tag, r_jitter, r_cycles;
    logic          r_fired, r_hit;

    logic          do_insert, do_remove;
    logic [CW-1:0] ins_pos, rem_pos;
    logic [TW-1:0] ins_time, clamp1;
    logic [WW-1:0] ins_tag;

    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_block_reg <= teq_pkg::MAX_BLOCK_RESET;
        end
        else if (cfg_valid)
        begin
            max_block_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            rq_func_reg   <= func;
            rq_time_reg   <= timecode;
            rq_key_reg    <= event_key;
            rq_tag_reg    <= event_tag;
            rq_target_reg <= target_id;
            rq_now_reg    <= now_time;
            rq_budget_reg <= cycle_budget;
        end
    end

    // placement and id search over all live entries
    always_comb
    begin
        logic head_first;
        pos_next = count_reg;
        mpos_next = '0;
        found_next = 1'b0;
        for (int j = D - 1; j >= 1; j--)
        begin
            if (CW'(j) < count_reg && slot_time_reg[j] > rq_time_reg)
            begin
                pos_next = CW'(j);
            end
        end
        if (count_reg == CW'(1))
        begin
            head_first = rq_time_reg <= slot_time_reg[0];
        end
        else
        begin
            head_first = slot_time_reg[0] > rq_time_reg;
        end
        if (count_reg == '0 || head_first)
        begin
            pos_next = '0;
        end
        for (int j = D - 1; j >= 0; j--)
        begin
            if (CW'(j) < count_reg && slot_id_reg[j] == rq_target_reg)
            begin
                mpos_next = CW'(j);
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find)
        begin
            pos_reg        <= pos_next;
            mpos_reg       <= mpos_next;
            found_reg      <= found_next;
            due_reg        <= (rq_time_reg == '0) || (rq_time_reg <= rq_now_reg);
            head_ready_reg <= rq_now_reg >= slot_time_reg[0];
            late_reg       <= rq_now_reg - slot_time_reg[0];
            early_reg      <= slot_time_reg[0] - rq_now_reg;
        end
    end

    // execute one request
    always_comb
    begin
        r_status = teq_pkg::ST_OK;
        r_assigned = '0;
        r_fired = 1'b0;
        r_key = '0;
        r_tag = '0;
        r_hit = 1'b0;
        r_jitter = '0;
        r_cycles = '0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        ins_pos = pos_reg;
        rem_pos = mpos_reg;
        ins_time = rq_time_reg;
        ins_tag = '0;
        next_id_next = next_id_reg;
        clamp1 = early_reg;
        if (early_reg > TW'(max_block_reg))
        begin
            clamp1 = TW'(max_block_reg);
        end
        case (rq_func_reg)
            teq_pkg::FUNC_ADD_RUN, teq_pkg::FUNC_ADD_ONLY, teq_pkg::FUNC_ADD_HEAD:
            begin
                next_id_next = next_id_reg + WW'(1);
                if (rq_func_reg == teq_pkg::FUNC_ADD_RUN && due_reg)
                begin
                    r_fired = 1'b1;
                    r_key = rq_key_reg;
                end
                else if (count_reg == CW'(D))
                begin
                    r_status = teq_pkg::ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    r_assigned = next_id_reg;
                    if (rq_func_reg == teq_pkg::FUNC_ADD_HEAD || due_reg)
                    begin
                        ins_pos = '0;
                    end
                    if (rq_func_reg == teq_pkg::FUNC_ADD_HEAD)
                    begin
                        ins_time = '0;
                    end
                    if (rq_func_reg == teq_pkg::FUNC_ADD_ONLY)
                    begin
                        ins_tag = rq_tag_reg;
                    end
                end
            end
            teq_pkg::FUNC_DELETE:
            begin
                if (count_reg == '0)
                begin
                    r_status = teq_pkg::ST_EMPTY;
                end
                else if (rq_target_reg != '0)
                begin
                    if (found_reg)
                    begin
                        do_remove = 1'b1;
                    end
                    else
                    begin
                        r_status = teq_pkg::ST_NOT_FOUND;
                    end
                end
            end
            teq_pkg::FUNC_SERVICE:
            begin
                if (count_reg == '0)
                begin
                    r_status = teq_pkg::ST_EMPTY;
                end
                else if (head_ready_reg)
                begin
                    do_remove = 1'b1;
                    rem_pos = '0;
                    r_fired = 1'b1;
                    r_key = slot_key_reg[0];
                    r_tag = slot_tag_reg[0];
                    r_hit = slot_tag_reg[0] == rq_tag_reg;
                    r_jitter = (late_reg[TW-1:WW] != '0) ? '1 : late_reg[WW-1:0];
                end
                else
                begin
                    r_status = teq_pkg::ST_NOT_DUE;
                    r_cycles = (clamp1 > TW'(rq_budget_reg)) ? rq_budget_reg
                                                              : clamp1[WW-1:0];
                end
            end
            default:
            begin
                r_status = teq_pkg::ST_OK;
            end
        endcase
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // each slot loads from a neighbor or the new event
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < D; i++)
            begin
                if (do_insert)
                begin
                    if (CW'(i) == ins_pos)
                    begin
                        slot_time_reg[i] <= ins_time;
                        slot_key_reg[i]  <= rq_key_reg;
                        slot_id_reg[i]   <= next_id_reg;
                        slot_tag_reg[i]  <= ins_tag;
                    end
                    else if (i > 0 && CW'(i) > ins_pos)
                    begin
                        slot_time_reg[i] <= slot_time_reg[(i + D - 1) % D];
                        slot_key_reg[i]  <= slot_key_reg[(i + D - 1) % D];
                        slot_id_reg[i]   <= slot_id_reg[(i + D - 1) % D];
                        slot_tag_reg[i]  <= slot_tag_reg[(i + D - 1) % D];
                    end
                end
                else if (do_remove && i < D - 1 && CW'(i) >= rem_pos)
                begin
                    slot_time_reg[i] <= slot_time_reg[(i + 1) % D];
                    slot_key_reg[i]  <= slot_key_reg[(i + 1) % D];
                    slot_id_reg[i]   <= slot_id_reg[(i + 1) % D];
                    slot_tag_reg[i]  <= slot_tag_reg[(i + 1) % D];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            next_id_reg   <= teq_pkg::FIRST_ID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg     <= count_next;
                next_id_reg   <= next_id_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg      <= r_status;
            assigned_id_reg <= r_assigned;
            fired_reg       <= r_fired;
            fired_key_reg   <= r_key;
            fired_tag_reg   <= r_tag;
            tag_hit_reg     <= r_hit;
            jitter_reg      <= r_jitter;
            cycles_reg      <= r_cycles;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign assigned_id   = assigned_id_reg;
    assign fired         = fired_reg;
    assign fired_key     = fired_key_reg;
    assign fired_tag     = fired_tag_reg;
    assign tag_hit       = tag_hit_reg;
    assign jitter        = jitter_reg;
    assign cycles_to_run = cycles_reg;

endmodule

>>> src/timed_event_queue.sv
// top level of the timed event queue
// usage:
//   in channel (in_valid/in_ready) carries one request: func, timecode,
//   event_key, event_tag, target_id, now_time, cycle_budget
//   out channel (out_valid/out_ready) returns exactly one result per request
//   cfg channel (cfg_valid/cfg_ready) writes the block size limit; always
//   ready, write only while no request is in flight
// timing:
//   a request is taken in the idle state, passes through the search pass
//   (parallel time and id compares over the table) and then execute,
//   where the table shifts by one slot; the result is valid the cycle after
//   execute
//   a new request is taken the cycle after execute, so requests do not
//   overlap: the next one waits until the last one has executed
// reset:
//   table empty, next id 100, block limit 4096; no clearing pass
// stall:
//   a held result stays in the output register; the next request is still
//   taken and waits in execute until the output register frees
module timed_event_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [47:0] timecode,
    input  logic [31:0] event_key,
    input  logic [31:0] event_tag,
    input  logic [31:0] target_id,
    input  logic [47:0] now_time,
    input  logic [31:0] cycle_budget,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] assigned_id,
    output logic        fired,
    output logic [31:0] fired_key,
    output logic [31:0] fired_tag,
    output logic        tag_hit,
    output logic [31:0] jitter,
    output logic [31:0] cycles_to_run
);

    teq_pkg::cmd_t  cmd;
    teq_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    teq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    teq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .func          (func),
        .timecode      (timecode),
        .event_key     (event_key),
        .event_tag     (event_tag),
        .target_id     (target_id),
        .now_time      (now_time),
        .cycle_budget  (cycle_budget),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .assigned_id   (assigned_id),
        .fired         (fired),
        .fired_key     (fired_key),
        .fired_tag     (fired_tag),
        .tag_hit       (tag_hit),
        .jitter        (jitter),
        .cycles_to_run (cycles_to_run)
    );

endmodule

>>> bench/timed_event_queue_chk.sv
// checker for the timed event queue: predicts every result and compares it
module timed_event_queue_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  func,
    input  logic [47:0] timecode,
    input  logic [31:0] event_key,
    input  logic [31:0] event_tag,
    input  logic [31:0] target_id,
    input  logic [47:0] now_time,
    input  logic [31:0] cycle_budget,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [31:0] assigned_id,
    input  logic        fired,
    input  logic [31:0] fired_key,
    input  logic [31:0] fired_tag,
    input  logic        tag_hit,
    input  logic [31:0] jitter,
    input  logic [31:0] cycles_to_run,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          fires_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] assigned_id;
        logic        fired;
        logic [31:0] fired_key;
        logic [31:0] fired_tag;
        logic        tag_hit;
        logic [31:0] jitter;
        logic [31:0] cycles_to_run;
    } teq_result_t;

    typedef struct packed {
        logic [47:0] due;
        logic [31:0] key;
        logic [31:0] id;
        logic [31:0] tag;
    } teq_event_t;

    teq_event_t  sched[$];
    teq_result_t expected_results[$];
    logic [31:0] id_model;
    logic [31:0] block_limit;

    function automatic int place_for(logic [47:0] t);
        int i;
        i = 0;
        if (sched.size() == 0) return 0;
        if (sched.size() == 1) return (t <= sched[0].due) ? 0 : 1;
        if (sched[0].due > t) return 0;
        while (i + 1 < sched.size() && sched[i+1].due <= t) i++;
        return i + 1;
    endfunction

    task automatic schedule_request(input logic [2:0] f, input logic [47:0] t,
                                    input logic [31:0] key, input logic [31:0] tag,
                                    input logic [31:0] target, input logic [47:0] now,
                                    input logic [31:0] budget);
        teq_result_t r;
        teq_event_t  e;
        logic        due;
        logic [31:0] id;
        logic [47:0] span;
        int          pos;
        r = '0;
        due = (t == 0) || (t <= now);
        if (f == teq_pkg::FUNC_ADD_RUN || f == teq_pkg::FUNC_ADD_ONLY ||
            f == teq_pkg::FUNC_ADD_HEAD) begin
            id = id_model;
            id_model = id_model + 1;
            if (f == teq_pkg::FUNC_ADD_RUN && due) begin
                r.fired = 1'b1;
                r.fired_key = key;
            end else if (sched.size() >= teq_pkg::DEPTH) begin
                r.status = teq_pkg::ST_FULL;
            end else begin
                e.key = key;
                e.id = id;
                if (f == teq_pkg::FUNC_ADD_HEAD) begin
                    e.due = '0;
                    e.tag = '0;
                    sched.push_front(e);
                end else begin
                    e.due = t;
                    e.tag = (f == teq_pkg::FUNC_ADD_ONLY) ? tag : '0;
                    pos = due ? 0 : place_for(t);
                    sched.insert(pos, e);
                end
                r.assigned_id = id;
            end
        end else if (f == teq_pkg::FUNC_DELETE) begin
            if (sched.size() == 0) r.status = teq_pkg::ST_EMPTY;
            else if (target != 0) begin
                r.status = teq_pkg::ST_NOT_FOUND;
                foreach (sched[i]) begin
                    if (sched[i].id == target) begin
                        sched.delete(i);
                        r.status = teq_pkg::ST_OK;
                        break;
                    end
                end
            end
        end else if (f == teq_pkg::FUNC_SERVICE) begin
            if (sched.size() == 0) r.status = teq_pkg::ST_EMPTY;
            else if (now >= sched[0].due) begin
                span = now - sched[0].due;
                r.fired = 1'b1;
                r.fired_key = sched[0].key;
                r.fired_tag = sched[0].tag;
                r.tag_hit = (sched[0].tag == tag);
                r.jitter = (span > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
                void'(sched.pop_front());
            end else begin
                span = sched[0].due - now;
                if (span > {16'd0, block_limit}) span = {16'd0, block_limit};
                if (span > {16'd0, budget}) span = {16'd0, budget};
                r.status = teq_pkg::ST_NOT_DUE;
                r.cycles_to_run = span[31:0];
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        teq_result_t got, want;
        if (!rst_n) begin
            sched.delete();
            expected_results.delete();
            id_model = teq_pkg::FIRST_ID;
            block_limit <= teq_pkg::MAX_BLOCK_RESET;
            errors <= 0;
            pending <= 0;
            results_seen <= 0;
            fires_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) block_limit <= cfg_data;
            // result first: a request accepted now cannot already have its result
            if (out_valid && out_ready) begin
                got = '{status, assigned_id, fired, fired_key, fired_tag, tag_hit,
                        jitter, cycles_to_run};
                results_seen <= results_seen + 1;
                if (fired) fires_seen <= fires_seen + 1;
                if (expected_results.size() == 0) begin
                    if (errors < 10) $display("unexpected result %p", got);
                    errors <= errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("mismatch at %0t\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                schedule_request(func, timecode, event_key, event_tag, target_id,
                                 now_time, cycle_budget);
            pending <= expected_results.size();
        end
    end
endmodule

>>> bench/timed_event_queue_tb.sv
// stimulus and verdict for the timed event queue
module timed_event_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  func = '0;
    logic [47:0] timecode = '0;
    logic [31:0] event_key = '0;
    logic [31:0] event_tag = '0;
    logic [31:0] target_id = '0;
    logic [47:0] now_time = '0;
    logic [31:0] cycle_budget = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic        fired;
    logic [31:0] fired_key;
    logic [31:0] fired_tag;
    logic        tag_hit;
    logic [31:0] jitter;
    logic [31:0] cycles_to_run;
    int          errors, pending, results_seen, fires_seen;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic [47:0] clock_now = 48'd1000;
    logic [31:0] id_guess = teq_pkg::FIRST_ID;
    int          n_items = 0;

    always #2 clk = ~clk;

    timed_event_queue uut (.*);
    timed_event_queue_chk chk (.*);

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // valid stays high between back-to-back requests; it drops only when idling
    task automatic send_request(input logic [2:0] f, input logic [47:0] t,
                                input logic [31:0] key, input logic [31:0] tag,
                                input logic [31:0] target, input logic [47:0] now,
                                input logic [31:0] budget);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        func <= f;
        timecode <= t;
        event_key <= key;
        event_tag <= tag;
        target_id <= target;
        now_time <= now;
        cycle_budget <= budget;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (f <= teq_pkg::FUNC_ADD_HEAD) id_guess = id_guess + 1;
        n_items++;
    endtask

    task automatic write_block_limit(input logic [31:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed traffic around a moving clock, with wide noise mixed in
    task automatic random_request();
        logic [2:0]  f;
        logic [47:0] t, now;
        logic [31:0] target, tag;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 35) f = teq_pkg::FUNC_ADD_ONLY;
        else if (sel < 50) f = teq_pkg::FUNC_ADD_RUN;
        else if (sel < 55) f = teq_pkg::FUNC_ADD_HEAD;
        else if (sel < 65) f = teq_pkg::FUNC_DELETE;
        else if (sel < 97) f = teq_pkg::FUNC_SERVICE;
        else f = 3'($urandom_range(7, 5));
        if ($urandom_range(9) == 0) clock_now = 48'({$urandom, $urandom});
        else clock_now = clock_now + $urandom_range(300);
        now = clock_now;
        sel = $urandom_range(9);
        if (sel == 0) t = '0;
        else if (sel == 1) t = 48'({$urandom, $urandom});
        else if (sel == 2) t = now - $urandom_range(50);
        else if (sel == 3) t = now + 48'h1_0000_0000 + $urandom;
        else t = now + $urandom_range(6000);
        sel = $urandom_range(9);
        if (sel < 6) target = id_guess - $urandom_range(1, 40);
        else if (sel < 7) target = '0;
        else target = $urandom;
        tag = ($urandom_range(1)) ? 32'($urandom_range(3)) : $urandom;
        send_request(f, t, $urandom, tag, target, now,
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(8000));
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: empty table, instant fires, placement ties, deletes
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 0, 0);
        send_request(teq_pkg::FUNC_DELETE, 0, 0, 0, 5, 0, 0);
        send_request(teq_pkg::FUNC_ADD_RUN, 0, 32'hFFFF_FFFF, 0, 0, 10, 0);
        send_request(teq_pkg::FUNC_ADD_RUN, 5, 1, 0, 0, 10, 0);
        send_request(teq_pkg::FUNC_ADD_ONLY, 500, 2, 32'hFFFF_FFFF, 0, 10, 0);
        send_request(teq_pkg::FUNC_ADD_ONLY, 500, 3, 7, 0, 10, 0);
        send_request(teq_pkg::FUNC_ADD_ONLY, 500, 4, 8, 0, 10, 0);
        send_request(teq_pkg::FUNC_ADD_RUN, 48'hFFFF_FFFF_FFFF, 5, 9, 0, 10, 0);
        send_request(teq_pkg::FUNC_ADD_ONLY, 3, 6, 1, 0, 10, 0);
        send_request(teq_pkg::FUNC_ADD_HEAD, 999, 7, 1, 0, 10, 0);
        send_request(teq_pkg::FUNC_DELETE, 0, 0, 0, 0, 10, 0);
        send_request(teq_pkg::FUNC_DELETE, 0, 0, 0, 32'hFFFF_FFFF, 10, 0);
        send_request(teq_pkg::FUNC_DELETE, 0, 0, 0, 104, 10, 0);
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 1, 0, 10, 0);
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 7, 0, 200, 32'hFFFF_FFFF);
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 7, 0, 0, 3);
        send_request(3'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 34; i++)
            send_request(teq_pkg::FUNC_ADD_ONLY, 48'h8000_0000_0000 + i, i, i, 0, 10, 0);
        write_block_limit(32'd1);
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 10, 32'hFFFF_FFFF);
        write_block_limit(32'hFFFF_FFFF);
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 10, 32'hFFFF_FFFF);
        send_request(teq_pkg::FUNC_SERVICE, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
        while (n_items < 550) begin
            random_request();
            if (n_items % 60 == 0) begin
                case ((n_items / 60) % 4)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 55; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 55; end
                    default: begin send_idle_pct = 6; stall_pct = 6; end
                endcase
            end
            if (n_items % 150 == 0)
                write_block_limit(($urandom_range(1)) ? 32'($urandom_range(1, 5000))
                                                      : $urandom);
            // drain the table now and then so it does not sit full
            if (n_items % 97 == 0)
                repeat (32) send_request(teq_pkg::FUNC_SERVICE, 0, 0, 0, 0,
                                         48'hFFFF_FFFF_FFFF, 0);
        end
        in_valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("%0d requests sent, %0d results checked, %0d events fired",
                 n_items, results_seen, fires_seen);
        $display("covered all request types, full and empty table, several block limits");
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

>>> filelist.f
src/teq_pkg.sv
src/teq_ctrl.sv
src/teq_datapath.sv
src/timed_event_queue.sv
bench/timed_event_queue_chk.sv
bench/timed_event_queue_tb.sv
